// File: src/stvm_pkg.sv
// Shared opcodes, flag and result types for the stack VM ALU and flag unit.
package stvm_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 5;

    localparam logic [OpW-1:0] OP_AND  = 5'd0;
    localparam logic [OpW-1:0] OP_TEST = 5'd1;
    localparam logic [OpW-1:0] OP_XOR  = 5'd2;
    localparam logic [OpW-1:0] OP_OR   = 5'd3;
    localparam logic [OpW-1:0] OP_NOT  = 5'd4;
    localparam logic [OpW-1:0] OP_SHL  = 5'd5;
    localparam logic [OpW-1:0] OP_SHR  = 5'd6;
    localparam logic [OpW-1:0] OP_ROTL = 5'd7;
    localparam logic [OpW-1:0] OP_ROTR = 5'd8;
    localparam logic [OpW-1:0] OP_ADDF = 5'd9;
    localparam logic [OpW-1:0] OP_SUBF = 5'd10;
    localparam logic [OpW-1:0] OP_ADD  = 5'd11;
    localparam logic [OpW-1:0] OP_SUB  = 5'd12;
    localparam logic [OpW-1:0] OP_JZ   = 5'd13;
    localparam logic [OpW-1:0] OP_JNZ  = 5'd14;
    localparam logic [OpW-1:0] OP_JE   = 5'd15;
    localparam logic [OpW-1:0] OP_JNE  = 5'd16;
    localparam logic [OpW-1:0] OP_JB   = 5'd17;
    localparam logic [OpW-1:0] OP_JNB  = 5'd18;
    localparam logic [OpW-1:0] OP_JA   = 5'd19;
    localparam logic [OpW-1:0] OP_JNA  = 5'd20;
    localparam logic [OpW-1:0] OP_JEB  = 5'd21;
    localparam logic [OpW-1:0] OP_JNEB = 5'd22;
    localparam logic [OpW-1:0] OP_JEA  = 5'd23;
    localparam logic [OpW-1:0] OP_JNEA = 5'd24;

    typedef struct packed {
        logic infinity;
        logic nan;
        logic overflow;
        logic sign;
        logic carry;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic [WordW-1:0] result;
        logic             writes_result;
        logic             branch_taken;
        flags_t           flags;
    } exec_res_t;

endpackage

// File: src/stvm_alu.sv
// Combinational ALU, flag update and branch condition evaluation for one item.
module stvm_alu (
    input  logic [stvm_pkg::OpW-1:0]   opcode,
    input  logic [stvm_pkg::WordW-1:0] operand_a,
    input  logic [stvm_pkg::WordW-1:0] operand_b,
    input  stvm_pkg::flags_t           flags_in,
    output stvm_pkg::exec_res_t        res
);

    logic [stvm_pkg::WordW:0]   sum;
    logic [stvm_pkg::WordW:0]   diff;
    logic [stvm_pkg::WordW-1:0] value;
    logic                       carry;
    logic                       logic_op;
    logic                       arith_op;
    logic                       wr;
    logic                       taken;
    logic                       cond_eq;
    logic                       cond_bl;
    logic                       cond_ab;
    logic                       exp_ones;
    logic                       mant_nz;

    assign sum  = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff = {1'b0, operand_a} - {1'b0, operand_b};

    assign cond_eq = flags_in.zero & ~flags_in.carry & ~flags_in.sign;
    assign cond_bl = ~flags_in.zero & flags_in.carry & flags_in.sign;
    assign cond_ab = ~flags_in.zero & ~flags_in.carry & ~flags_in.sign;

    always_comb begin
        value    = '0;
        carry    = 1'b0;
        logic_op = 1'b0;
        arith_op = 1'b0;
        wr       = 1'b0;
        taken    = 1'b0;
        unique case (opcode)
            stvm_pkg::OP_AND: begin
                value = operand_a & operand_b; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_TEST: begin
                value = operand_a & operand_b; logic_op = 1'b1;
            end
            stvm_pkg::OP_XOR: begin
                value = operand_a ^ operand_b; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_OR: begin
                value = operand_a | operand_b; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_NOT: begin
                value = ~operand_a; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_SHL: begin
                value = {operand_a[stvm_pkg::WordW-2:0], 1'b0};
                carry = operand_a[stvm_pkg::WordW-1]; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_SHR: begin
                value = {1'b0, operand_a[stvm_pkg::WordW-1:1]};
                carry = operand_a[0]; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_ROTL: begin
                value = {operand_a[stvm_pkg::WordW-2:0], operand_a[stvm_pkg::WordW-1]};
                carry = operand_a[stvm_pkg::WordW-1]; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_ROTR: begin
                value = {operand_a[0], operand_a[stvm_pkg::WordW-1:1]};
                carry = operand_a[0]; wr = 1'b1; logic_op = 1'b1;
            end
            stvm_pkg::OP_ADDF: begin
                value = sum[stvm_pkg::WordW-1:0];
                carry = sum[stvm_pkg::WordW]; wr = 1'b1; arith_op = 1'b1;
            end
            stvm_pkg::OP_SUBF: begin
                // borrow out of the 33-bit difference is a < b
                value = diff[stvm_pkg::WordW-1:0];
                carry = diff[stvm_pkg::WordW]; wr = 1'b1; arith_op = 1'b1;
            end
            stvm_pkg::OP_ADD: begin
                value = sum[stvm_pkg::WordW-1:0]; wr = 1'b1;
            end
            stvm_pkg::OP_SUB: begin
                value = diff[stvm_pkg::WordW-1:0]; wr = 1'b1;
            end
            stvm_pkg::OP_JZ:   taken = flags_in.zero;
            stvm_pkg::OP_JNZ:  taken = ~flags_in.zero;
            stvm_pkg::OP_JE:   taken = cond_eq;
            stvm_pkg::OP_JNE:  taken = ~cond_eq;
            stvm_pkg::OP_JB:   taken = cond_bl;
            stvm_pkg::OP_JNB:  taken = ~cond_bl;
            stvm_pkg::OP_JA:   taken = cond_ab;
            stvm_pkg::OP_JNA:  taken = ~cond_ab;
            stvm_pkg::OP_JEB:  taken = cond_eq | cond_bl;
            stvm_pkg::OP_JNEB: taken = ~(cond_eq | cond_bl);
            stvm_pkg::OP_JEA:  taken = cond_eq | cond_ab;
            stvm_pkg::OP_JNEA: taken = ~(cond_eq | cond_ab);
            default: ;
        endcase
    end

    assign exp_ones = &value[30:23];
    assign mant_nz  = |value[22:0];

    always_comb begin
        res.result        = value;
        res.writes_result = wr;
        res.branch_taken  = taken;
        res.flags         = flags_in;
        if (logic_op || arith_op) begin
            res.flags.zero     = (value == '0);
            res.flags.sign     = value[stvm_pkg::WordW-1];
            res.flags.overflow = value[stvm_pkg::WordW-1] ^ operand_a[stvm_pkg::WordW-1];
            res.flags.carry    = carry;
        end
        // flag-setting add/sub keep nan and infinity
        if (logic_op) begin
            res.flags.nan      = exp_ones & mant_nz;
            res.flags.infinity = exp_ones & ~mant_nz;
        end
    end

endmodule

// File: src/stack_vm_alu_flag_unit_core.sv
// Stack VM ALU and flag unit: input register, single-pass execute, result register.
// Throughput: one item per cycle while m_ready does not stall the output; the
// execute logic is a 33-bit adder and subtractor, logic and shift ops plus flag
// logic between the two registers, and the flags feed the next item.
// Reset (aresetn low, synchronous): both stages empty, all six flags cleared.
module stack_vm_alu_flag_unit_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [stvm_pkg::OpW-1:0]   s_opcode,
    input  logic [stvm_pkg::WordW-1:0] s_operand_a,
    input  logic [stvm_pkg::WordW-1:0] s_operand_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [stvm_pkg::WordW-1:0] m_result,
    output logic                       m_writes_result,
    output logic                       m_branch_taken,
    output logic                       m_zero_out,
    output logic                       m_carry_out,
    output logic                       m_sign_out,
    output logic                       m_overflow_out,
    output logic                       m_nan_out,
    output logic                       m_infinity_out
);

    logic                       in_valid_reg;
    logic [stvm_pkg::OpW-1:0]   in_op_reg;
    logic [stvm_pkg::WordW-1:0] in_a_reg;
    logic [stvm_pkg::WordW-1:0] in_b_reg;
    stvm_pkg::flags_t           flags_reg;
    logic                       out_valid_reg;
    stvm_pkg::exec_res_t        out_reg;
    stvm_pkg::exec_res_t        exec_next;
    logic                       adv;

    // item moves from input reg to result reg
    assign adv     = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | adv;

    stvm_alu u_alu (
        .opcode    (in_op_reg),
        .operand_a (in_a_reg),
        .operand_b (in_b_reg),
        .flags_in  (flags_reg),
        .res       (exec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (~out_valid_reg | m_ready) out_valid_reg <= in_valid_reg;
            if (adv) flags_reg <= exec_next.flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg <= s_opcode;
            in_a_reg  <= s_operand_a;
            in_b_reg  <= s_operand_b;
        end
        if (adv) out_reg <= exec_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_result        = out_reg.result;
    assign m_writes_result = out_reg.writes_result;
    assign m_branch_taken  = out_reg.branch_taken;
    assign m_zero_out      = out_reg.flags.zero;
    assign m_carry_out     = out_reg.flags.carry;
    assign m_sign_out      = out_reg.flags.sign;
    assign m_overflow_out  = out_reg.flags.overflow;
    assign m_nan_out       = out_reg.flags.nan;
    assign m_infinity_out  = out_reg.flags.infinity;

    // branch and unused opcodes leave the flags alone
    a_branch_keeps_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_op_reg >= stvm_pkg::OP_JZ) |=> flags_reg == $past(flags_reg))
        else $error("flags changed on a branch item");

    a_arith_keeps_fp: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (in_op_reg == stvm_pkg::OP_ADDF || in_op_reg == stvm_pkg::OP_SUBF))
        |=> (flags_reg.nan == $past(flags_reg.nan)
             && flags_reg.infinity == $past(flags_reg.infinity)))
        else $error("nan/infinity changed on flag-setting add/sub");

    a_out_flags_current: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_reg.flags == flags_reg)
        else $error("result flags differ from stored flags");

    a_branch_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.branch_taken)
        |-> (!out_reg.writes_result && out_reg.result == '0))
        else $error("taken branch carries a result");

endmodule
